@@ rtl/core/wttc_pkg.sv @@
`default_nettype none

package wttc_pkg;

  // Input item kinds, carried on s_tuser.
  typedef enum logic [1:0] {
    OP_EXP_BYTE = 2'd0,
    OP_ACT_BYTE = 2'd1,
    OP_EXP_END  = 2'd2,
    OP_ACT_END  = 2'd3
  } op_t;

  // Class of the whitespace run that precedes a token byte.
  typedef enum logic [1:0] {
    SEP_NONE  = 2'd0,
    SEP_SPACE = 2'd1,
    SEP_LINE  = 2'd2
  } sep_t;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_VERDICT = 1'b1
  } cmd_kind_t;

  // A queued token byte: the separator class sits above the byte.
  typedef struct packed {
    sep_t       sep;
    logic [7:0] data;
  } entry_t;

  // Work handed from the classifier to the comparison engine.
  typedef struct packed {
    cmd_kind_t kind;
    logic      side;   // 0 expected, 1 actual
    entry_t    entry;
  } cmd_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_line_byte(input logic [7:0] b);
    return (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_white_byte(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) ||
           is_line_byte(b);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/whitespace_tolerant_token_compare.sv @@
// Whitespace-tolerant token comparator.
// Input channel (s_*): one transfer per byte or end marker. s_tuser says what the
// transfer is (expected byte, actual byte, end of expected, end of actual) and
// s_tdata carries the byte. The two streams may be interleaved in any order.
// Output channel (m_*): one transfer per comparison, issued once both end markers
// have arrived; it reports whether the token sequences (with their separator
// classes) agree and whether a token queue overflowed.
// Throughput is one input transfer per cycle while the command queue has room,
// set by the classifier and the token queue, which does one push or one pop per
// byte. A verdict request is registered in the command queue, which hands it on,
// and the comparison engine registers the verdict and raises m_tvalid.
// A stalled result stays in the output register; byte transfers keep flowing
// past it, and only a second verdict waits, so s_tready falls once the two-entry
// command queue behind it is full.
// Reset (rst, synchronous) empties both queues and clears all stream state; no
// clearing pass is needed, so the block accepts data the cycle after reset.
`default_nettype none

module whitespace_tolerant_token_compare #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic [1:0] s_tuser,   // [1:0] op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [0] match, [1] overflow, [7:2] zero
);

  // Front end: drops leading whitespace, folds whitespace runs into a class
  // and turns end markers into a verdict request.
  logic           front_push;
  wttc_pkg::cmd_t front_cmd;
  logic           fifo_full;
  logic           cmd_valid;
  logic           cmd_ready;
  wttc_pkg::cmd_t cmd;

  wttc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_byte  (s_tdata),
    .cmd_full (fifo_full),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  // Short decoupling queue so that a stalled verdict does not stop the front.
  wttc_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_cmd  (front_cmd),
    .full      (fifo_full),
    .pop_valid (cmd_valid),
    .pop_ready (cmd_ready),
    .pop_cmd   (cmd)
  );

  // Back end: token queue, pairwise comparison and the result register.
  wttc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // An overflow always forces a mismatch.
  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("match reported together with overflow");

  // A fresh result only follows a verdict request taken by the back end.
  a_result_from_verdict: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd_valid && cmd_ready && cmd.kind == wttc_pkg::CMD_VERDICT))
    else $error("result without a verdict request");

  // Nothing is presented on the output right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

`default_nettype wire

@@ rtl/core/wttc_front.sv @@
`default_nettype none

module wttc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_op,
  input  wire logic [7:0]      in_byte,
  input  wire logic            cmd_full,
  output logic                 cmd_push,
  output wttc_pkg::cmd_t       cmd
);

  logic           started [2];
  logic           started_next [2];
  wttc_pkg::sep_t pend [2];
  wttc_pkg::sep_t pend_next [2];
  logic           ended [2];
  logic           ended_next [2];
  logic           side;
  logic           white;
  logic           line;
  logic           accept;
  wttc_pkg::op_t  op;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    op    = wttc_pkg::op_t'(in_op);
    side  = in_op[0];
    white = wttc_pkg::is_white_byte(in_byte);
    line  = wttc_pkg::is_line_byte(in_byte);
    cmd_push         = 1'b0;
    cmd.kind         = wttc_pkg::CMD_BYTE;
    cmd.side         = side;
    cmd.entry.sep    = pend[side];
    cmd.entry.data   = in_byte;
    started_next     = started;
    pend_next        = pend;
    ended_next       = ended;
    if (accept) begin
      unique case (op)
        wttc_pkg::OP_EXP_BYTE, wttc_pkg::OP_ACT_BYTE: begin
          if (!ended[side]) begin
            if (white) begin
              // Whitespace before the first token is dropped; a line break wins.
              if (started[side] && (pend[side] == wttc_pkg::SEP_NONE || line)) begin
                pend_next[side] = line ? wttc_pkg::SEP_LINE : wttc_pkg::SEP_SPACE;
              end
            end else begin
              cmd_push          = 1'b1;
              pend_next[side]   = wttc_pkg::SEP_NONE;
              started_next[side] = 1'b1;
            end
          end
        end
        wttc_pkg::OP_EXP_END, wttc_pkg::OP_ACT_END: begin
          if (ended[!side]) begin
            // Both ends are in: ask for the verdict and start afresh.
            cmd_push     = 1'b1;
            cmd.kind     = wttc_pkg::CMD_VERDICT;
            started_next = '{1'b0, 1'b0};
            pend_next    = '{wttc_pkg::SEP_NONE, wttc_pkg::SEP_NONE};
            ended_next   = '{1'b0, 1'b0};
          end else begin
            ended_next[side] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= '{1'b0, 1'b0};
      pend    <= '{wttc_pkg::SEP_NONE, wttc_pkg::SEP_NONE};
      ended   <= '{1'b0, 1'b0};
    end else begin
      started <= started_next;
      pend    <= pend_next;
      ended   <= ended_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wttc_cmd_fifo.sv @@
`default_nettype none

module wttc_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire wttc_pkg::cmd_t  push_cmd,
  output logic                 full,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output wttc_pkg::cmd_t       pop_cmd
);

  wttc_pkg::cmd_t slot [2];
  logic           wp;
  logic           rp;
  logic [1:0]     level;
  logic           pop;

  assign full      = (level == 2'd2);
  assign pop_valid = (level != 2'd0);
  assign pop_cmd   = slot[rp];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wttc_back.sv @@
`default_nettype none

module wttc_back #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire wttc_pkg::cmd_t  cmd,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Only the side that is ahead ever holds entries, so one queue serves both.
  wttc_pkg::entry_t mem [QUEUE_DEPTH];
  wttc_pkg::entry_t rd_q;
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    count;
  logic             owner;
  logic             mismatch;
  logic             ovf;
  logic             res_match;
  logic             res_ovf;
  logic             take;
  logic             is_byte;
  logic             verdict;
  logic             same_side;
  logic             q_full;
  logic             wr_en;
  logic             pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd_ready = (cmd.kind == wttc_pkg::CMD_BYTE) || !m_tvalid || m_tready;
  assign take      = cmd_valid && cmd_ready;
  assign is_byte   = take && (cmd.kind == wttc_pkg::CMD_BYTE);
  assign verdict   = take && (cmd.kind == wttc_pkg::CMD_VERDICT);
  assign same_side = (count == '0) || (owner == cmd.side);
  assign q_full    = (count == CW'(QUEUE_DEPTH));
  assign wr_en     = is_byte && same_side && !q_full;
  assign pop       = is_byte && !same_side;
  assign m_tdata   = {6'b0, res_ovf, res_match};

  always_comb begin
    priority if (verdict) begin
      rd_addr = '0;
    end else if (pop) begin
      rd_addr = ptr_inc(rd_ptr);
    end else begin
      rd_addr = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cmd.entry;
    end
  end

  // rd_q always holds the head entry; a write to the head address is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_ptr == rd_addr)) begin
      rd_q <= cmd.entry;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      owner    <= 1'b0;
      mismatch <= 1'b0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (verdict) begin
        wr_ptr   <= '0;
        rd_ptr   <= '0;
        count    <= '0;
        owner    <= 1'b0;
        mismatch <= 1'b0;
        ovf      <= 1'b0;
        m_tvalid <= 1'b1;
      end else begin
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (is_byte && same_side && q_full) begin
          ovf <= 1'b1;
        end
        if (wr_en) begin
          wr_ptr <= ptr_inc(wr_ptr);
          count  <= count + 1'b1;
          owner  <= cmd.side;
        end
        if (pop) begin
          rd_ptr <= rd_addr;
          count  <= count - 1'b1;
          if (rd_q != cmd.entry) begin
            mismatch <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (verdict) begin
      res_match <= !mismatch && !ovf && (count == '0);
      res_ovf   <= ovf;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/whitespace_tolerant_token_compare_test.sv @@
`timescale 1ns / 1ps

module whitespace_tolerant_token_compare_test;

  localparam int QUEUE_SLOTS    = 64;
  localparam int ITEM_TARGET    = 1650;
  // Receiver hold-off long enough for several verdicts to back up behind the
  // output register, so that the command queue fills and s_tready drops.
  localparam int HOLD_CYCLES    = 200;
  // Cycles without any transfer on either side before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Wait after the last owed verdict is checked, leaving room for a spurious extra one.
  localparam int DRAIN_CYCLES   = 12;

  // Whitespace bytes: the first four form a space-class run, the last two
  // make a run count as a line break.
  localparam logic [7:0] WHITES [0:5] = '{wttc_pkg::CH_SPACE, wttc_pkg::CH_TAB,
                                          wttc_pkg::CH_VT, wttc_pkg::CH_FF,
                                          wttc_pkg::CH_LF, wttc_pkg::CH_CR};

  // How the actual stream is altered from the expected one.
  typedef enum int {
    EDIT_NONE,
    EDIT_BYTE,
    EDIT_SEP,
    EDIT_DROP,
    EDIT_ADD
  } edit_t;

  // Order in which the two streams are fed to the block.
  typedef enum int {
    ORDER_MIXED,
    ORDER_EXP_FIRST,
    ORDER_ACT_FIRST
  } order_t;

  typedef struct packed {
    logic is_match;
    logic overflow;
  } verdict_t;

  function automatic wttc_pkg::sep_t byte_class(logic [7:0] b);
    case (b)
      wttc_pkg::CH_LF, wttc_pkg::CH_CR: return wttc_pkg::SEP_LINE;
      wttc_pkg::CH_SPACE, wttc_pkg::CH_TAB, wttc_pkg::CH_VT, wttc_pkg::CH_FF:
        return wttc_pkg::SEP_SPACE;
      default: return wttc_pkg::SEP_NONE;
    endcase
  endfunction

  // Tracks the comparator's stream state as transfers are accepted and keeps
  // the verdicts still owed by the block, oldest first.
  class token_verdict_board #(int DEPTH = 64);
    bit               started [2];
    wttc_pkg::sep_t   pend_sep [2];
    bit               ended [2];
    wttc_pkg::entry_t tokens [2][$];
    bit               mismatch;
    bit               overflowed;
    verdict_t         verdicts_due [$];
    int               failures;
    int               verdicts;
    int               match_count;
    int               overflows;

    function new();
      clear();
    endfunction

    function void clear();
      for (int s = 0; s < 2; s++) begin
        started[s] = 1'b0;
        pend_sep[s] = wttc_pkg::SEP_NONE;
        ended[s] = 1'b0;
        tokens[s].delete();
      end
      mismatch = 1'b0;
      overflowed = 1'b0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Returns 0 for a transfer the block ignores (its side has ended), else 1.
    function bit note_transfer(wttc_pkg::op_t op, logic [7:0] b);
      int               side;
      wttc_pkg::sep_t   cls;
      wttc_pkg::entry_t e;
      wttc_pkg::entry_t a;
      verdict_t         v;
      side = int'(op[0]);
      if (!op[1]) begin
        if (ended[side]) return 1'b0;
        cls = byte_class(b);
        if (cls != wttc_pkg::SEP_NONE) begin
          // Whitespace before the first token of a side is dropped.
          if (started[side] && cls > pend_sep[side]) pend_sep[side] = cls;
          return 1'b1;
        end
        e.sep = pend_sep[side];
        e.data = b;
        if (tokens[side].size() >= DEPTH) overflowed = 1'b1;
        else tokens[side].push_back(e);
        pend_sep[side] = wttc_pkg::SEP_NONE;
        started[side] = 1'b1;
        if (tokens[0].size() != 0 && tokens[1].size() != 0) begin
          e = tokens[0].pop_front();
          a = tokens[1].pop_front();
          if (e != a) mismatch = 1'b1;
        end
        return 1'b1;
      end
      if (ended[side]) return 1'b0;
      ended[side] = 1'b1;
      if (ended[0] && ended[1]) begin
        v.is_match = !mismatch && !overflowed && tokens[0].size() == 0 &&
                     tokens[1].size() == 0;
        v.overflow = overflowed;
        verdicts_due.push_back(v);
        verdicts++;
        match_count += int'(v.is_match);
        overflows += int'(v.overflow);
        clear();
      end
      return 1'b1;
    endfunction

    function void check_verdict(logic is_match, logic overflow);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none outstanding: match %0d, overflow %0d", is_match, overflow);
        failures++;
        return;
      end
      want = verdicts_due.pop_front();
      if (is_match !== want.is_match) begin
        $error("match: expected %0d, actual %0d", want.is_match, is_match);
        failures++;
      end
      if (overflow !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
        failures++;
      end
    endfunction
  endclass

  typedef token_verdict_board #(QUEUE_SLOTS) board_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [1:0] s_tuser = 2'b00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  board_t board = new();

  // Shared between the sender, the receiver and the watchdog.
  bit quiet = 1'b0;           // last part of the run: no idling on either side
  bit sender_gaps = 1'b0;     // current sequence may pause between transfers
  bit hold_request = 1'b0;    // asks the receiver for its long hold-off
  int counted = 0;            // transfers on a side not yet ended
  int ignored = 0;            // transfers after their side ended, which the block discards
  int longest_backpressure = 0;

  whitespace_tolerant_token_compare #(
    .QUEUE_DEPTH(QUEUE_SLOTS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task is entered just after a rising edge, so a transfer
  // is offered from that edge on and taken at the first later edge at which
  // s_tready (sampled before the edge updates) is high. s_tvalid is lowered
  // only when a gap follows, so it is never lowered and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(wttc_pkg::op_t op, logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    if (board.note_transfer(op, b)) counted++;
    else ignored++;
    if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_text(wttc_pkg::op_t op, string s);
    for (int i = 0; i < s.len(); i++) send_item(op, s[i]);
  endtask

  // A byte of the given class; SEP_NONE stands for any whitespace at all.
  function automatic logic [7:0] white_of(wttc_pkg::sep_t cls);
    case (cls)
      wttc_pkg::SEP_LINE:  return WHITES[$urandom_range(4, 5)];
      wttc_pkg::SEP_SPACE: return WHITES[$urandom_range(0, 3)];
      default:             return WHITES[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (byte_class(b) != wttc_pkg::SEP_NONE);
    return b;
  endfunction

  // A random tagged token sequence: each entry is a non-white byte together
  // with the class of the whitespace run in front of it.
  task automatic make_tagged(ref wttc_pkg::entry_t seq[$], input int len);
    wttc_pkg::entry_t e;
    int               r;
    seq.delete();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i == 0 || r < 55) e.sep = wttc_pkg::SEP_NONE;
      else if (r < 85) e.sep = wttc_pkg::SEP_SPACE;
      else e.sep = wttc_pkg::SEP_LINE;
      e.data = token_byte();
      seq.push_back(e);
    end
  endtask

  // Half the time the actual stream is left equal, otherwise one change is
  // made that should normally turn the verdict into a mismatch.
  task automatic perturb(ref wttc_pkg::entry_t seq[$]);
    edit_t            edit;
    wttc_pkg::entry_t e;
    int               r;
    int               idx;
    r = $urandom_range(0, 99);
    if (r < 50) edit = EDIT_NONE;
    else if (r < 65) edit = EDIT_BYTE;
    else if (r < 80) edit = EDIT_SEP;
    else if (r < 90) edit = EDIT_DROP;
    else edit = EDIT_ADD;
    case (edit)
      EDIT_BYTE: if (seq.size() > 0) begin
        idx = $urandom_range(0, seq.size() - 1);
        do e.data = token_byte(); while (e.data == seq[idx].data);
        seq[idx].data = e.data;
      end
      EDIT_SEP: if (seq.size() > 1) begin
        idx = $urandom_range(1, seq.size() - 1);
        seq[idx].sep = (seq[idx].sep == wttc_pkg::SEP_LINE) ? wttc_pkg::SEP_SPACE
                                                            : wttc_pkg::SEP_LINE;
      end
      EDIT_DROP: if (seq.size() > 0) seq.delete($urandom_range(0, seq.size() - 1));
      EDIT_ADD: begin
        if (seq.size() == 0) e.sep = wttc_pkg::SEP_NONE;
        else if (white_of(wttc_pkg::SEP_NONE) == wttc_pkg::CH_LF) e.sep = wttc_pkg::SEP_LINE;
        else e.sep = wttc_pkg::SEP_SPACE;
        e.data = token_byte();
        seq.insert($urandom_range(0, seq.size()), e);
      end
      default: ;
    endcase
  endtask

  // Turns a tagged sequence into raw bytes with freshly chosen whitespace, so
  // the two sides of a matching pair still differ byte for byte.
  task automatic render(ref wttc_pkg::entry_t seq[$], ref logic [7:0] text[$]);
    int n;
    int k;
    text.delete();
    repeat ($urandom_range(0, 2)) text.push_back(white_of(wttc_pkg::SEP_NONE));
    foreach (seq[i]) begin
      if (i > 0 && seq[i].sep != wttc_pkg::SEP_NONE) begin
        n = $urandom_range(1, 3);
        k = $urandom_range(0, n - 1);
        for (int j = 0; j < n; j++) begin
          if (seq[i].sep == wttc_pkg::SEP_SPACE) text.push_back(white_of(wttc_pkg::SEP_SPACE));
          else if (j == k) text.push_back(white_of(wttc_pkg::SEP_LINE));
          else text.push_back(white_of(wttc_pkg::SEP_NONE));
        end
      end
      text.push_back(seq[i].data);
    end
    repeat ($urandom_range(0, 2)) text.push_back(white_of(wttc_pkg::SEP_NONE));
  endtask

  // Ends one side. While the other side is still open, a late byte or a
  // repeated end marker may follow; the block must ignore both.
  task automatic close_side(bit side, bit other_open);
    send_item(side ? wttc_pkg::OP_ACT_END : wttc_pkg::OP_EXP_END, 8'($urandom_range(0, 255)));
    if (other_open && $urandom_range(0, 5) == 0)
      send_item(side ? wttc_pkg::OP_ACT_BYTE : wttc_pkg::OP_EXP_BYTE,
                8'($urandom_range(0, 255)));
    if (other_open && $urandom_range(0, 5) == 0)
      send_item(side ? wttc_pkg::OP_ACT_END : wttc_pkg::OP_EXP_END,
                8'($urandom_range(0, 255)));
  endtask

  task automatic send_streams(ref logic [7:0] exp_txt[$], ref logic [7:0] act_txt[$],
                              input order_t order);
    int ie;
    int ia;
    bit e_end;
    bit a_end;
    bit e_left;
    bit a_left;
    bit side;
    ie = 0;
    ia = 0;
    e_end = 1'b0;
    a_end = 1'b0;
    while (!(e_end && a_end)) begin
      e_left = ie < exp_txt.size();
      a_left = ia < act_txt.size();
      if (!e_left && !e_end && (!a_left || $urandom_range(0, 3) == 0)) begin
        close_side(1'b0, !a_end);
        e_end = 1'b1;
      end else if (!a_left && !a_end && (!e_left || $urandom_range(0, 3) == 0)) begin
        close_side(1'b1, !e_end);
        a_end = 1'b1;
      end else begin
        if (e_left && a_left) begin
          case (order)
            ORDER_EXP_FIRST: side = 1'b0;
            ORDER_ACT_FIRST: side = 1'b1;
            default:         side = 1'($urandom_range(0, 1));
          endcase
        end else begin
          side = !e_left;
        end
        if (side) begin
          send_item(wttc_pkg::OP_ACT_BYTE, act_txt[ia]);
          ia++;
        end else begin
          send_item(wttc_pkg::OP_EXP_BYTE, exp_txt[ie]);
          ie++;
        end
      end
    end
  endtask

  task automatic run_sequence(int len, order_t order);
    wttc_pkg::entry_t exp_seq[$];
    wttc_pkg::entry_t act_seq[$];
    logic [7:0]       exp_txt[$];
    logic [7:0]       act_txt[$];
    make_tagged(exp_seq, len);
    act_seq = exp_seq;
    perturb(act_seq);
    render(exp_seq, exp_txt);
    render(act_seq, act_txt);
    send_streams(exp_txt, act_txt, order);
  endtask

  // Unstructured transfers, then the end markers still missing so the next
  // sequence starts from a cleared state whatever the noise left behind.
  task automatic send_noise();
    int         r;
    logic [7:0] b;
    repeat ($urandom_range(5, 20)) begin
      r = $urandom_range(0, 9);
      b = ($urandom_range(0, 9) < 4) ? white_of(wttc_pkg::SEP_NONE)
                                     : 8'($urandom_range(0, 255));
      if (r < 4) send_item(wttc_pkg::OP_EXP_BYTE, b);
      else if (r < 8) send_item(wttc_pkg::OP_ACT_BYTE, b);
      else if (r == 8) send_item(wttc_pkg::OP_EXP_END, b);
      else send_item(wttc_pkg::OP_ACT_END, b);
    end
    if (!board.ended[0] && !board.ended[1])
      send_item(wttc_pkg::OP_EXP_END, 8'($urandom_range(0, 255)));
    if (board.ended[0]) send_item(wttc_pkg::OP_ACT_END, 8'($urandom_range(0, 255)));
    else send_item(wttc_pkg::OP_EXP_END, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int     seq_no;
    int     r;
    int     len;
    order_t order;
    bit     pressure_done;
    seq_no = 0;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Two empty streams match.
    send_item(wttc_pkg::OP_EXP_END, 8'h00);
    send_item(wttc_pkg::OP_ACT_END, 8'hFF);
    // Streams of nothing but whitespace also match, whatever the classes.
    send_item(wttc_pkg::OP_EXP_BYTE, wttc_pkg::CH_SPACE);
    send_item(wttc_pkg::OP_EXP_BYTE, wttc_pkg::CH_LF);
    send_item(wttc_pkg::OP_EXP_BYTE, wttc_pkg::CH_VT);
    send_item(wttc_pkg::OP_ACT_BYTE, wttc_pkg::CH_TAB);
    send_item(wttc_pkg::OP_ACT_BYTE, wttc_pkg::CH_FF);
    send_item(wttc_pkg::OP_ACT_BYTE, wttc_pkg::CH_CR);
    send_item(wttc_pkg::OP_EXP_END, 8'h55);
    send_item(wttc_pkg::OP_ACT_END, 8'hAA);
    // Extreme byte values with space-class runs of different bytes; the
    // actual side ends first, repeats its end marker and sends a late byte.
    send_item(wttc_pkg::OP_EXP_BYTE, 8'h00);
    send_item(wttc_pkg::OP_ACT_BYTE, 8'h00);
    send_item(wttc_pkg::OP_EXP_BYTE, wttc_pkg::CH_SPACE);
    send_item(wttc_pkg::OP_ACT_BYTE, wttc_pkg::CH_TAB);
    send_item(wttc_pkg::OP_EXP_BYTE, 8'hFF);
    send_item(wttc_pkg::OP_ACT_BYTE, 8'hFF);
    send_item(wttc_pkg::OP_ACT_END, 8'h00);
    send_item(wttc_pkg::OP_ACT_END, 8'h00);
    send_item(wttc_pkg::OP_ACT_BYTE, "x");
    send_item(wttc_pkg::OP_EXP_END, 8'h00);
    // Same tokens, but a space on one side against a line break on the other.
    send_text(wttc_pkg::OP_EXP_BYTE, "a b");
    send_text(wttc_pkg::OP_ACT_BYTE, "a");
    send_item(wttc_pkg::OP_ACT_BYTE, wttc_pkg::CH_CR);
    send_text(wttc_pkg::OP_ACT_BYTE, "b");
    send_item(wttc_pkg::OP_EXP_END, 8'h00);
    send_item(wttc_pkg::OP_ACT_END, 8'h00);

    // Random part: mostly well-formed stream pairs with random content.
    while (counted < ITEM_TARGET) begin
      quiet = counted >= ITEM_TARGET * 85 / 100;
      if (!pressure_done && counted >= ITEM_TARGET * 2 / 5) begin
        // Long receiver hold-off while short pairs keep coming back to back,
        // so finished verdicts pile up and the input is stalled.
        pressure_done = 1'b1;
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        repeat (8) run_sequence($urandom_range(0, 3), ORDER_MIXED);
      end
      sender_gaps = !quiet && $urandom_range(0, 2) != 0;
      if (seq_no == 0) begin
        // One side runs far ahead: its queue overflows.
        run_sequence(70, ORDER_EXP_FIRST);
      end else if (seq_no == 1) begin
        run_sequence(QUEUE_SLOTS + 2, ORDER_ACT_FIRST);
      end else if (seq_no == 2) begin
        // Exactly fills the queue without overflowing.
        run_sequence(QUEUE_SLOTS, ORDER_EXP_FIRST);
      end else if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(0, 12);
        else if (r < 95) len = $urandom_range(13, 40);
        else len = $urandom_range(60, 75);
        r = $urandom_range(0, 9);
        if (len >= 60 || r >= 7) order = r[0] ? ORDER_EXP_FIRST : ORDER_ACT_FIRST;
        else order = ORDER_MIXED;
        run_sequence(len, order);
      end
      seq_no++;
    end

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d effective and %0d ignored transfers in %0d random sequences.",
             counted, ignored, seq_no);
    $display("Checked %0d verdicts (%0d matching, %0d overflowed); longest input stall %0d.",
             board.verdicts, board.match_count, board.overflows, longest_backpressure);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: checks every accepted verdict and throttles m_tready in
  // random bursts, with calm stretches, the long hold-off, and none at the end.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int stall_left;
    int cycle_no;
    bit bursty;
    hold_left = 0;
    stall_left = 0;
    cycle_no = 0;
    bursty = 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_verdict(m_tdata[0], m_tdata[1]);
      cycle_no++;
      if (cycle_no % 64 == 0) bursty = 1'($urandom_range(0, 1));
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && bursty && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: gives up when neither side has moved a transfer for too long.
  initial begin
    int idle_cycles;
    int stall_run;
    idle_cycles = 0;
    stall_run = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (s_tvalid && !s_tready) stall_run++;
      else stall_run = 0;
      if (stall_run > longest_backpressure) longest_backpressure = stall_run;
    end
    $display("Timed out after %0d cycles without a transfer.", idle_cycles);
    $display("status: fail");
    $finish;
  end

endmodule
